// ----- hdl/mstk_pkg.sv -----
package mstk_pkg;

	localparam int unsigned DEPTH  = 1024;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ENTRY_W = 2 * DATA_W;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic push_en;
		logic pop_en;
		logic capture;
		logic load_top;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

// ----- hdl/mstk_ctrl.sv -----
module mstk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	output logic               out_valid,
	input  logic               out_ready,
	input  mstk_pkg::dp_stat_t dp_stat,
	output mstk_pkg::dp_cmd_t  dp_cmd
);

	mstk_pkg::state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mstk_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		dp_cmd   = '0;
		unique case (state_q)
			mstk_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_cmd.capture = 1'b1;
					if (cmd == mstk_pkg::CMD_PUSH) begin
						dp_cmd.push_en = !dp_stat.full;
						state_d        = mstk_pkg::ST_RESP;
					end else if (cmd == mstk_pkg::CMD_POP && !dp_stat.empty) begin
						dp_cmd.pop_en = 1'b1;
						state_d       = mstk_pkg::ST_FETCH;
					end else begin
						state_d = mstk_pkg::ST_RESP;
					end
				end
			end
			mstk_pkg::ST_FETCH: begin
				dp_cmd.load_top = 1'b1;
				state_d         = mstk_pkg::ST_RESP;
			end
			mstk_pkg::ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					dp_cmd.load_out = 1'b1;
					state_d         = mstk_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mstk_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/mstk_dp.sv -----
module mstk_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [1:0]                             cmd,
	input  logic signed [mstk_pkg::DATA_W-1:0]     push_value,
	input  mstk_pkg::dp_cmd_t                      dp_cmd,
	output mstk_pkg::dp_stat_t                     dp_stat,
	output logic signed [mstk_pkg::DATA_W-1:0]     top_value,
	output logic signed [mstk_pkg::DATA_W-1:0]     min_value,
	output logic                                   not_empty,
	output logic [mstk_pkg::CNT_W-1:0]             entry_count,
	output logic [1:0]                             status
);

	localparam int unsigned DW = mstk_pkg::DATA_W;

	logic [mstk_pkg::ENTRY_W-1:0] mem [mstk_pkg::DEPTH];
	logic [mstk_pkg::ENTRY_W-1:0] rd_q;
	logic [mstk_pkg::ENTRY_W-1:0] top_q;
	logic [mstk_pkg::CNT_W-1:0]   sp_q;
	mstk_pkg::status_t            status_q;
	mstk_pkg::status_t            status_d;

	logic signed [DW-1:0]          top_min;
	logic signed [DW-1:0]          new_min;
	logic [mstk_pkg::ADDR_W-1:0]   rd_addr;
	logic [mstk_pkg::ADDR_W-1:0]   wr_addr;

	logic signed [DW-1:0]          top_value_q;
	logic signed [DW-1:0]          min_value_q;
	logic                          not_empty_q;
	logic [mstk_pkg::CNT_W-1:0]    entry_count_q;
	logic [1:0]                    status_out_q;

	assign dp_stat.full  = (sp_q == mstk_pkg::CNT_W'(mstk_pkg::DEPTH));
	assign dp_stat.empty = (sp_q == '0);

	assign top_min = $signed(top_q[mstk_pkg::ENTRY_W-1:DW]);
	assign new_min = (!dp_stat.empty && (top_min < push_value)) ? top_min : push_value;
	assign wr_addr = sp_q[mstk_pkg::ADDR_W-1:0];
	assign rd_addr = sp_q[mstk_pkg::ADDR_W-1:0] - mstk_pkg::ADDR_W'(2);

	always_comb begin
		status_d = mstk_pkg::STAT_OK;
		if (cmd == mstk_pkg::CMD_PUSH && dp_stat.full) begin
			status_d = mstk_pkg::STAT_FULL;
		end else if (cmd == mstk_pkg::CMD_POP && dp_stat.empty) begin
			status_d = mstk_pkg::STAT_EMPTY;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.push_en) begin
			mem[wr_addr] <= {new_min, push_value};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (dp_cmd.push_en) begin
			sp_q <= sp_q + mstk_pkg::CNT_W'(1);
		end else if (dp_cmd.pop_en) begin
			sp_q <= sp_q - mstk_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.push_en) begin
			top_q <= {new_min, push_value};
		end else if (dp_cmd.load_top) begin
			top_q <= rd_q;
		end
		if (dp_cmd.capture) begin
			status_q <= status_d;
		end
		if (dp_cmd.load_out) begin
			top_value_q   <= dp_stat.empty ? '0 : $signed(top_q[DW-1:0]);
			min_value_q   <= dp_stat.empty ? '0 : top_min;
			not_empty_q   <= !dp_stat.empty;
			entry_count_q <= sp_q;
			status_out_q  <= status_q;
		end
	end

	assign top_value   = top_value_q;
	assign min_value   = min_value_q;
	assign not_empty   = not_empty_q;
	assign entry_count = entry_count_q;
	assign status      = status_out_q;

endmodule

// ----- hdl/min_stack_paired_entries_unit.sv -----
// channel   handshake             payload
// request   in_valid / in_ready   cmd, push_value
// result    out_valid / out_ready top_value, min_value, not_empty, entry_count, status
//
// push and read go straight to the response state, a non-empty pop via the fetch
// state: the entry below the cached top comes from the memory's registered read port
// the result sits in an output register, so a new request is taken while it waits
// arst_n clears the entry count and the handshake state; the memory is not cleared
// a stalled result holds the next request in the response state until taken
module min_stack_paired_entries_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             cmd,
	input  logic signed [mstk_pkg::DATA_W-1:0]     push_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [mstk_pkg::DATA_W-1:0]     top_value,
	output logic signed [mstk_pkg::DATA_W-1:0]     min_value,
	output logic                                   not_empty,
	output logic [mstk_pkg::CNT_W-1:0]             entry_count,
	output logic [1:0]                             status
);

	mstk_pkg::dp_cmd_t  dp_cmd;
	mstk_pkg::dp_stat_t dp_stat;

	mstk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_stat   (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	mstk_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.push_value  (push_value),
		.dp_cmd      (dp_cmd),
		.dp_stat     (dp_stat),
		.top_value   (top_value),
		.min_value   (min_value),
		.not_empty   (not_empty),
		.entry_count (entry_count),
		.status      (status)
	);

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !not_empty |-> top_value == '0 && min_value == '0)
		else $error("empty result carries nonzero top or min");

	a_count_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> not_empty == (entry_count != '0))
		else $error("not_empty disagrees with entry_count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mstk_pkg::STAT_FULL |->
		entry_count == mstk_pkg::CNT_W'(mstk_pkg::DEPTH))
		else $error("refused push with stack not full");

	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_empty |-> min_value <= top_value)
		else $error("minimum above top value");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.push_en |-> !dp_stat.full)
		else $error("push into full stack");

endmodule
